### src/assert_macros.svh
// Assertion helpers for the list manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PLM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PLM_ASSERT(lbl, clk, rst, prop, msg)
`define PLM_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### src/plm_pkg.sv
package plm_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int OP_W     = 3;
  localparam int POS_W    = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 7;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_AT   = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_AT   = 3'd5,
    OP_DUMP     = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_INVALID = 3'd2,
    ST_OUTSIDE = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DUMP,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_NEW
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t sel;
    value_t    value;
  } cell_cmd_t;

endpackage

### src/plm_in_if.sv
interface plm_in_if;
  import plm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [POS_W-1:0]  position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

### src/plm_out_if.sv
interface plm_out_if;
  import plm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] element;
  logic [LEN_W-1:0]         length;
  logic                     last;

  modport source (output valid, status, element, length, last, input ready);
  modport sink   (input valid, status, element, length, last, output ready);
endinterface

### src/positional_list_manager_top.sv
// Channel  Dir  Fields                          Transaction
// req      in   op, position, value             valid && ready
// rsp      out  status, element, length, last   valid && ready
//
// Insert and delete ops finish once the request is held and the output is free:
// every cell of the ring shifts toward or away from the target position at once.
// Dump turns the whole ring once, pausing on output stalls and emitting the first
// length entries; the next request is held meanwhile.
// Reset clears the element count and control; cell contents are not reset.
// One request is held while a result waits in the output register.
module positional_list_manager_top (
  input logic clk,
  input logic rst,
  plm_in_if.sink    req,
  plm_out_if.source rsp
);
  import plm_pkg::*;

  value_t    cell_value [CAPACITY];
  cell_cmd_t cmd        [CAPACITY];

  plm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .head_value (cell_value[0]),
    .cmd        (cmd)
  );

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    localparam int LeftJ  = (j + CAPACITY - 1) % CAPACITY;
    localparam int RightJ = (j + 1) % CAPACITY;

    plm_cell u_cell (
      .clk   (clk),
      .left  (cell_value[LeftJ]),
      .right (cell_value[RightJ]),
      .cmd   (cmd[j]),
      .value (cell_value[j])
    );
  end

endmodule

### src/plm_cell.sv
module plm_cell (
  input  logic               clk,
  input  plm_pkg::value_t    left,
  input  plm_pkg::value_t    right,
  input  plm_pkg::cell_cmd_t cmd,
  output plm_pkg::value_t    value
);
  import plm_pkg::*;

  value_t value_next;

  always_comb begin
    unique case (cmd.sel)
      SEL_LEFT:  value_next = left;
      SEL_RIGHT: value_next = right;
      SEL_NEW:   value_next = cmd.value;
      default:   value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### src/plm_ctrl.sv
`include "assert_macros.svh"

module plm_ctrl (
  input  logic                clk,
  input  logic                rst,
  plm_in_if.sink              req,
  plm_out_if.source           rsp,
  input  plm_pkg::value_t     head_value,
  output plm_pkg::cell_cmd_t  cmd [plm_pkg::CAPACITY]
);
  import plm_pkg::*;

  // input holding register
  logic                     in_held;
  op_t                      in_op;
  logic signed [POS_W-1:0]  in_pos;
  logic signed [DATA_W-1:0] in_value;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] rot;
  logic [CNT_W-1:0] rot_inc;

  logic             slot_free;
  logic             exec;
  logic             rotate;
  logic             dump_emit;

  // decoded operation
  status_t          st;
  logic             ins_go;
  logic             del_go;
  logic             dump_go;
  logic [IDX_W-1:0] k;

  logic             full;
  logic             pos_low;
  logic [POS_W-1:0] pos_u;
  logic [POS_W-1:0] cnt_w;
  logic [IDX_W-1:0] k_at;

  assign slot_free = !rsp.valid || rsp.ready;
  assign exec      = in_held && (state == S_IDLE) && slot_free;
  assign req.ready = !in_held || exec;
  assign rot_inc   = rot + CNT_W'(1);

  assign full    = (count == CNT_W'(CAPACITY));
  assign pos_low = (in_pos < POS_W'(signed'(1)));
  assign pos_u   = {1'b0, in_pos[POS_W-2:0]};
  assign cnt_w   = POS_W'(count);
  assign k_at    = IDX_W'(pos_u - POS_W'(1));

  always_comb begin
    st      = ST_OK;
    ins_go  = 1'b0;
    del_go  = 1'b0;
    dump_go = 1'b0;
    k       = '0;
    case (in_op)
      OP_INS_HEAD: begin
        if (full) st = ST_FULL;
        else ins_go = 1'b1;
      end
      OP_INS_TAIL: begin
        k = IDX_W'(count);
        if (full) st = ST_FULL;
        else ins_go = 1'b1;
      end
      OP_INS_AT: begin
        k = k_at;
        if (pos_low) st = ST_INVALID;
        else if (full) st = ST_FULL;
        else if (pos_u > cnt_w + POS_W'(1)) st = ST_OUTSIDE;
        else ins_go = 1'b1;
      end
      OP_DEL_HEAD: begin
        if (count == '0) st = ST_EMPTY;
        else del_go = 1'b1;
      end
      OP_DEL_TAIL: begin
        k = IDX_W'(count - CNT_W'(1));
        if (count == '0) st = ST_EMPTY;
        else del_go = 1'b1;
      end
      OP_DEL_AT: begin
        k = k_at;
        if (count == '0) st = ST_EMPTY;
        else if (pos_low) st = ST_INVALID;
        else if (pos_u > cnt_w) st = ST_OUTSIDE;
        else del_go = 1'b1;
      end
      OP_DUMP: begin
        if (count == '0) st = ST_EMPTY;
        else dump_go = 1'b1;
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    count_next = count;
    if (exec && ins_go) count_next = count + CNT_W'(1);
    else if (exec && del_go) count_next = count - CNT_W'(1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (exec && dump_go) state_next = S_DUMP;
      end
      S_DUMP: begin
        if (slot_free && rot_inc == count) begin
          state_next = (rot_inc == CNT_W'(CAPACITY)) ? S_IDLE : S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (rot_inc == CNT_W'(CAPACITY)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    rotate    = 1'b0;
    dump_emit = 1'b0;
    unique case (state)
      S_IDLE: ;
      S_DUMP: begin
        rotate    = slot_free;
        dump_emit = slot_free;
      end
      S_FLUSH: rotate = 1'b1;
      default: ;
    endcase
  end

  // per-cell shift selects: open a gap, close a gap, or turn the ring
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      cmd[j].value = VALUE_BITS'(in_value);
      cmd[j].sel   = SEL_HOLD;
      if (rotate) begin
        cmd[j].sel = SEL_RIGHT;
      end else if (exec && ins_go) begin
        if (IDX_W'(j) > k) cmd[j].sel = SEL_LEFT;
        else if (IDX_W'(j) == k) cmd[j].sel = SEL_NEW;
      end else if (exec && del_go) begin
        if (IDX_W'(j) >= k) cmd[j].sel = SEL_RIGHT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held   <= 1'b0;
      state     <= S_IDLE;
      count     <= '0;
      rot       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (req.valid && req.ready) in_held <= 1'b1;
      else if (exec) in_held <= 1'b0;
      if (exec) rot <= '0;
      else if (rotate) rot <= rot_inc;
      if ((exec && !dump_go) || dump_emit) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op    <= op_t'(req.op);
      in_pos   <= req.position;
      in_value <= req.value;
    end
    if (dump_emit) begin
      rsp.status  <= ST_OK;
      rsp.element <= DATA_W'(signed'(head_value));
      rsp.length  <= LEN_W'(count);
      rsp.last    <= (rot_inc == count);
    end else if (exec && !dump_go) begin
      rsp.status  <= st;
      rsp.element <= '0;
      rsp.length  <= LEN_W'(count_next);
      rsp.last    <= 1'b1;
    end
  end

  `PLM_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY), "element count overflow")
  `PLM_ASSERT(a_dump_rot, clk, rst, (state == S_DUMP) |-> (rot < count), "dump ran past end")
  `PLM_ASSERT(a_count_hold, clk, rst, !exec |=> $stable(count), "count moved without an op")
  `PLM_ASSERT(a_dump_last, clk, rst, (dump_emit && rot_inc == count) |=> (rsp.valid && rsp.last), "dump missed last flag")

endmodule
